>>> src/hsd_pkg.sv
package hsd_pkg;

  typedef struct packed {
    logic [7:0] compressed_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic       symbol_valid;
    logic [7:0] symbol;
    logic       run_last;
    logic       stream_end;
    logic       format_error;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_PAD   = 3'd1,
    PH_TAG   = 3'd2,
    PH_SYM   = 3'd3,
    PH_MSG   = 3'd4,
    PH_ERR   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_RD1,
    ST_RD2,
    ST_EMIT,
    ST_DONE
  } fsm_t;

endpackage

>>> src/huffman_stream_decoder.sv
// Busy time: a byte keeps the decoder busy from when it is taken until ST_DONE closes it. Header,
// leaf tag and symbol bits take ST_BIT; internal-node, link and last symbol bits add ST_RD1; message
// bits pass ST_BIT, ST_RD1, ST_RD2 and ST_EMIT on a leaf; output stalls add to this.
// Throughput: one byte at a time; the next byte is taken in the idle cycle that follows.
// Each result is held one behind and leaves when the next is found or when the byte closes.
// Reset: synchronous, active high; clears stream state, the node store and stack are not cleared.
module huffman_stream_decoder #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hsd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hsd_pkg::out_item_t  out_data
);

  localparam int NodeDepth = 2 * ALPHABET_SIZE;
  localparam int NW = $clog2(NodeDepth);
  localparam int SW = $clog2(ALPHABET_SIZE);

  typedef struct packed {
    logic [NW-1:0] left;
    logic [NW-1:0] right;
    logic [7:0]    sym;
  } node_t;

  node_t         node_mem [NodeDepth];
  logic [NW-1:0] stack_mem [ALPHABET_SIZE];

  hsd_pkg::fsm_t   st, st_next;
  hsd_pkg::phase_t phase;
  logic [7:0]  byte_q;
  logic        fin_q;
  logic [3:0]  bit_idx;
  logic [SW:0] stack_depth;
  logic [7:0]  header_shift;
  logic [3:0]  header_bits;
  logic [SW:0] symbol_count;
  logic [2:0]  pad_count;
  logic [SW:0] leaves_seen;
  logic [NW-1:0] parse_node;
  logic [NW:0]   next_free;
  logic          skip_link_bit;
  logic [NW-1:0] walk_node;

  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  node_t         mem_wdata;
  logic [NW-1:0] mem_raddr;
  node_t         mem_rdata;
  logic          stk_we;
  logic [SW-1:0] stk_addr;
  logic [NW-1:0] stk_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= node_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_addr] <= parse_node;
    end
    stk_rdata <= stack_mem[stk_addr];
  end

  logic b;
  logic fin_ok;
  logic [NW-1:0] child;
  assign b = byte_q[3'd7 - bit_idx[2:0]];
  assign fin_ok = !(fin_q && ({1'b0, bit_idx} >= (5'd8 - {2'b0, pad_count})));
  assign child = b ? mem_rdata.right : mem_rdata.left;

  logic pend_err;
  logic pend_sym;
  logic [7:0] pend_val;
  logic hold_have;
  logic hold_err;
  logic hold_sym;
  logic [7:0] hold_val;
  logic out_free;
  logic out_load;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((st == hsd_pkg::ST_EMIT && hold_have) ||
                                 (st == hsd_pkg::ST_DONE && (hold_have || fin_q)));

  // The TAG step updates the parent link, and the SYM step the leaf symbol, with a read-modify-write of the node store.
  always_comb begin
    st_next   = st;
    mem_we    = 1'b0;
    mem_waddr = parse_node;
    mem_wdata = '0;
    mem_raddr = walk_node;
    stk_we    = 1'b0;
    stk_addr  = stack_depth[SW-1:0];
    case (st)
      hsd_pkg::ST_IDLE: begin
        if (in_valid) begin
          st_next = hsd_pkg::ST_BIT;
        end
      end
      hsd_pkg::ST_BIT: begin
        if (bit_idx == 4'd8) begin
          st_next = hsd_pkg::ST_DONE;
        end else begin
          case (phase)
            hsd_pkg::PH_PAD: begin
              if (header_bits == 4'd2) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
              end
            end
            hsd_pkg::PH_TAG: begin
              mem_raddr = parse_node;
              if (skip_link_bit || b) begin
                if (next_free < NodeDepth[NW:0] &&
                    (skip_link_bit || stack_depth < ALPHABET_SIZE[SW:0])) begin
                  mem_we    = 1'b1;
                  mem_waddr = next_free[NW-1:0];
                  st_next   = hsd_pkg::ST_RD1;
                  if (!skip_link_bit) begin
                    stk_we = 1'b1;
                  end
                end else begin
                  st_next = hsd_pkg::ST_EMIT;
                end
              end
            end
            hsd_pkg::PH_SYM: begin
              mem_raddr = parse_node;
              if (header_bits == 4'd7) begin
                st_next = hsd_pkg::ST_RD1;
                stk_addr = stack_depth[SW-1:0] - 1'b1;
              end
            end
            hsd_pkg::PH_MSG: begin
              mem_raddr = walk_node;
              if (fin_ok) begin
                st_next = hsd_pkg::ST_RD1;
              end
            end
            default: ;
          endcase
        end
      end
      hsd_pkg::ST_RD1: begin
        if (phase == hsd_pkg::PH_MSG) begin
          mem_raddr = (child != '0) ? child : walk_node;
          st_next = hsd_pkg::ST_RD2;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = parse_node;
          mem_wdata = mem_rdata;
          if (phase == hsd_pkg::PH_TAG) begin
            if (skip_link_bit) begin
              mem_wdata.right = next_free[NW-1:0];
            end else begin
              mem_wdata.left = next_free[NW-1:0];
            end
          end else begin
            mem_wdata.sym = {header_shift[6:0], b};
          end
          st_next = hsd_pkg::ST_BIT;
        end
      end
      hsd_pkg::ST_RD2: begin
        st_next = (mem_rdata.left == '0 && mem_rdata.right == '0) ?
                  hsd_pkg::ST_EMIT : hsd_pkg::ST_BIT;
      end
      hsd_pkg::ST_EMIT: begin
        if (!hold_have || out_free) begin
          st_next = hsd_pkg::ST_BIT;
        end
      end
      hsd_pkg::ST_DONE: begin
        if (!(hold_have || fin_q) || out_free) begin
          st_next = hsd_pkg::ST_IDLE;
        end
      end
      default: st_next = hsd_pkg::ST_IDLE;
    endcase
  end

  assign in_stall = rst || (st != hsd_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hsd_pkg::ST_IDLE;
      phase <= hsd_pkg::PH_COUNT;
      stack_depth <= '0;
      header_shift <= '0;
      header_bits <= '0;
      symbol_count <= '0;
      pad_count <= '0;
      leaves_seen <= '0;
      parse_node <= '0;
      next_free <= (NW+1)'(1);
      skip_link_bit <= 1'b0;
      walk_node <= '0;
      bit_idx <= '0;
      pend_err <= 1'b0;
      pend_sym <= 1'b0;
      pend_val <= '0;
      hold_have <= 1'b0;
      hold_err <= 1'b0;
      hold_sym <= 1'b0;
      hold_val <= '0;
    end else begin
      st <= st_next;
      case (st)
        hsd_pkg::ST_IDLE: begin
          if (in_valid) begin
            byte_q  <= in_data.compressed_byte;
            fin_q   <= in_data.final_byte;
            bit_idx <= '0;
          end
        end
        hsd_pkg::ST_BIT: begin
          if (bit_idx != 4'd8) begin
            case (phase)
              hsd_pkg::PH_COUNT: begin
                if (header_bits == 4'd7) begin
                  if ({header_shift[6:0], b} == 8'd0 ||
                      {1'b0, header_shift[6:0], b} > ALPHABET_SIZE[8:0]) begin
                    symbol_count <= ALPHABET_SIZE[SW:0];
                  end else begin
                    symbol_count <= (SW+1)'({header_shift[6:0], b});
                  end
                  header_shift <= '0;
                  header_bits <= '0;
                  phase <= hsd_pkg::PH_PAD;
                end else begin
                  header_shift <= {header_shift[6:0], b};
                  header_bits <= header_bits + 1'b1;
                end
                bit_idx <= bit_idx + 1'b1;
              end
              hsd_pkg::PH_PAD: begin
                if (header_bits == 4'd2) begin
                  pad_count <= {header_shift[1:0], b};
                  header_shift <= '0;
                  header_bits <= '0;
                  next_free <= (NW+1)'(1);
                  parse_node <= '0;
                  stack_depth <= '0;
                  leaves_seen <= '0;
                  skip_link_bit <= 1'b0;
                  phase <= hsd_pkg::PH_TAG;
                end else begin
                  header_shift <= {header_shift[6:0], b};
                  header_bits <= header_bits + 1'b1;
                end
                bit_idx <= bit_idx + 1'b1;
              end
              hsd_pkg::PH_TAG: begin
                if (skip_link_bit || b) begin
                  if (next_free < NodeDepth[NW:0] &&
                      (skip_link_bit || stack_depth < ALPHABET_SIZE[SW:0])) begin
                    if (!skip_link_bit) begin
                      stack_depth <= stack_depth + 1'b1;
                    end
                  end else begin
                    pend_err <= 1'b1;
                    pend_sym <= 1'b0;
                    pend_val <= '0;
                    phase <= hsd_pkg::PH_ERR;
                  end
                end else begin
                  header_shift <= '0;
                  header_bits <= '0;
                  phase <= hsd_pkg::PH_SYM;
                  bit_idx <= bit_idx + 1'b1;
                end
              end
              hsd_pkg::PH_SYM: begin
                if (header_bits != 4'd7) begin
                  header_shift <= {header_shift[6:0], b};
                  header_bits <= header_bits + 1'b1;
                  bit_idx <= bit_idx + 1'b1;
                end
              end
              hsd_pkg::PH_MSG: begin
                if (!fin_ok) begin
                  bit_idx <= 4'd8;
                end
              end
              default: bit_idx <= 4'd8;
            endcase
          end
        end
        hsd_pkg::ST_RD1: begin
          if (phase == hsd_pkg::PH_MSG) begin
            if (child != '0) begin
              walk_node <= child;
            end
          end else if (phase == hsd_pkg::PH_TAG) begin
            parse_node <= next_free[NW-1:0];
            next_free <= next_free + 1'b1;
            skip_link_bit <= 1'b0;
            bit_idx <= bit_idx + 1'b1;
          end else begin
            header_shift <= '0;
            header_bits <= '0;
            bit_idx <= bit_idx + 1'b1;
            leaves_seen <= leaves_seen + 1'b1;
            if (leaves_seen + 1'b1 >= symbol_count || stack_depth == '0) begin
              walk_node <= '0;
              phase <= hsd_pkg::PH_MSG;
            end else begin
              stack_depth <= stack_depth - 1'b1;
              parse_node <= stk_rdata;
              skip_link_bit <= 1'b1;
              phase <= hsd_pkg::PH_TAG;
            end
          end
        end
        hsd_pkg::ST_RD2: begin
          bit_idx <= bit_idx + 1'b1;
          if (mem_rdata.left == '0 && mem_rdata.right == '0) begin
            pend_err <= 1'b0;
            pend_sym <= 1'b1;
            pend_val <= mem_rdata.sym;
            walk_node <= '0;
          end
        end
        hsd_pkg::ST_EMIT: begin
          // A new result pushes the held one out; the new one waits for the next.
          if (!hold_have || out_free) begin
            if (hold_have) begin
              out_data <= '{symbol_valid: hold_sym, symbol: hold_val, run_last: 1'b0,
                            stream_end: 1'b0, format_error: hold_err};
            end
            hold_have <= 1'b1;
            hold_sym <= pend_sym;
            hold_val <= pend_val;
            hold_err <= pend_err;
            if (pend_err) begin
              bit_idx <= 4'd8;
            end
          end
        end
        hsd_pkg::ST_DONE: begin
          if (out_load) begin
            out_data <= '{symbol_valid: hold_have & hold_sym,
                          symbol: hold_have ? hold_val : 8'd0, run_last: 1'b1,
                          stream_end: fin_q, format_error: hold_have & hold_err};
            hold_have <= 1'b0;
            if (fin_q) begin
              phase <= hsd_pkg::PH_COUNT;
              stack_depth <= '0;
              header_shift <= '0;
              header_bits <= '0;
              symbol_count <= '0;
              pad_count <= '0;
              leaves_seen <= '0;
              parse_node <= '0;
              next_free <= (NW+1)'(1);
              skip_link_bit <= 1'b0;
              walk_node <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (st != hsd_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (stack_depth <= ALPHABET_SIZE[SW:0]))
    else $error("stack depth overflow");

endmodule
